// ===== hw/rtl/pitvt_pkg.sv =====
// shared types and constants for the tip-volume point test
// no dependencies
`default_nettype none

package pitvt_pkg;

  // register indexes on the config port (byte address is 4 * index)
  localparam logic [2:0] REG_BASE_RADIUS   = 3'd0;
  localparam logic [2:0] REG_TOP_RADIUS    = 3'd1;
  localparam logic [2:0] REG_BOTTOM_CAP_H  = 3'd2;
  localparam logic [2:0] REG_TOP_CAP_H     = 3'd3;
  localparam logic [2:0] REG_FRUSTUM_H     = 3'd4;
  localparam logic [2:0] REG_CAP_EPSILON   = 3'd5;

  // region codes
  localparam logic [1:0] REGION_BODY   = 2'd0;
  localparam logic [1:0] REGION_BOTTOM = 2'd1;
  localparam logic [1:0] REGION_ABOVE  = 2'd2;

  // quotient bits of the radial divider and the cap-radius divider
  localparam int DIV_STEPS = 63;
  localparam logic [5:0] DIV_LAST = 6'(DIV_STEPS - 1);

  localparam logic [63:0] SAT64 = '1;

  typedef enum logic [1:0] {
    CAL_IDLE,
    CAL_SQUARE,
    CAL_DIV
  } cal_state_t;

  // per-point context carried alongside the divider
  typedef struct packed {
    logic [63:0] s;
    logic [1:0]  region;
    logic        cap_in;
    logic        hneg;
    logic        psign;
  } ctx_t;

endpackage

`default_nettype wire

// ===== hw/rtl/point_in_tip_volume_test_unit.sv =====
// top level of the tip-volume point test: config port, cap-radius calibration
// and the point pipeline; depends on pitvt_pkg
`default_nettype none

// Classifies one signed Q16.16 point per clock against a tip solid made of a
// conical frustum along z, a concave spherical cap cut from its base and a
// convex cap on its top. Once running, a new point is taken every cycle; the
// latency is set by the 63-step pipelined divider that forms the local radius
// rB - z*(rB-rT)/H. After reset and after every register write the block works
// out the two cap sphere radii with a shared one-bit-per-cycle divider, and
// holds s_tready low during that time; register writes are taken at any time.
// Output backpressure stalls the whole pipeline without losing a transaction.
module point_in_tip_volume_test_unit
  import pitvt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // point stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [95:0] s_tdata,   // pos_x, pos_y, pos_z
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata    // inside_res, region, zero fill
);

  // ---------------------------------------------------------------------------
  // config registers
  // ---------------------------------------------------------------------------
  logic [30:0] rb, rt, hb, ht, hh;
  logic [15:0] eps;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rb  <= 31'd65536;
      rt  <= 31'd32768;
      hb  <= '0;
      ht  <= '0;
      hh  <= 31'd65536;
      eps <= 16'd1;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_BASE_RADIUS:  rb  <= pwdata[30:0];
        REG_TOP_RADIUS:   rt  <= pwdata[30:0];
        REG_BOTTOM_CAP_H: hb  <= pwdata[30:0];
        REG_TOP_CAP_H:    ht  <= pwdata[30:0];
        REG_FRUSTUM_H:    hh  <= pwdata[30:0];
        REG_CAP_EPSILON:  eps <= pwdata[15:0];
        default: ;  // writes beyond the list are dropped
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_BASE_RADIUS:  prdata = {1'b0, rb};
      REG_TOP_RADIUS:   prdata = {1'b0, rt};
      REG_BOTTOM_CAP_H: prdata = {1'b0, hb};
      REG_TOP_CAP_H:    prdata = {1'b0, ht};
      REG_FRUSTUM_H:    prdata = {1'b0, hh};
      REG_CAP_EPSILON:  prdata = {16'd0, eps};
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // cap calibration: a2 = 2*floor((r*r + h*h) / (2*h)) for bottom, then top
  // ---------------------------------------------------------------------------
  cal_state_t  cal_state, cal_state_next;
  logic        cal_cap;          // 0 bottom cap, 1 top cap
  logic [5:0]  cal_cnt;
  logic [31:0] cal_rem;
  logic [62:0] cal_qd;
  logic [31:0] cal_d;
  logic [62:0] a_bot, a_top;     // twice the sphere radius, Q16.16
  logic        cal_load, cal_step, cal_store, cal_idle;
  logic [30:0] cal_r, cal_h;
  logic [32:0] cal_t;
  logic        cal_ge;
  logic [62:0] cal_qd_next;

  always_comb begin
    cal_state_next = cal_state;
    unique case (cal_state)
      CAL_IDLE:   cal_state_next = CAL_IDLE;
      CAL_SQUARE: cal_state_next = CAL_DIV;
      CAL_DIV: begin
        if (cal_cnt == DIV_LAST) begin
          cal_state_next = cal_cap ? CAL_IDLE : CAL_SQUARE;
        end
      end
      default:    cal_state_next = CAL_SQUARE;
    endcase
    // any register write invalidates both radii
    if (cfg_wr) begin
      cal_state_next = CAL_SQUARE;
    end
  end

  always_comb begin
    cal_load  = (cal_state == CAL_SQUARE);
    cal_step  = (cal_state == CAL_DIV);
    cal_store = (cal_state == CAL_DIV) && (cal_cnt == DIV_LAST);
    cal_idle  = (cal_state == CAL_IDLE);
  end

  assign cal_r       = cal_cap ? rt : rb;
  assign cal_h       = cal_cap ? ht : hb;
  assign cal_t       = {cal_rem, cal_qd[62]};
  assign cal_ge      = cal_t >= {1'b0, cal_d};
  assign cal_qd_next = {cal_qd[61:0], cal_ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_state <= CAL_SQUARE;
      cal_cap   <= 1'b0;
    end else begin
      cal_state <= cal_state_next;
      if (cfg_wr) begin
        cal_cap <= 1'b0;
      end else if (cal_store) begin
        cal_cap <= ~cal_cap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cal_load) begin
      cal_qd  <= 63'(62'(cal_r) * 62'(cal_r)) + 63'(62'(cal_h) * 62'(cal_h));
      cal_rem <= '0;
      cal_d   <= {cal_h, 1'b0};
      cal_cnt <= '0;
    end else if (cal_step) begin
      cal_rem <= cal_ge ? 32'(cal_t - {1'b0, cal_d}) : cal_t[31:0];
      cal_qd  <= cal_qd_next;
      cal_cnt <= cal_cnt + 6'd1;
    end
    if (cal_store) begin
      if (cal_cap) begin
        a_top <= {cal_qd_next[61:0], 1'b0};
      end else begin
        a_bot <= {cal_qd_next[61:0], 1'b0};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // point pipeline; every stage moves together when the output can take data
  // ---------------------------------------------------------------------------
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && cal_idle;

  // stage 1: register the coordinates
  logic               v1;
  logic signed [31:0] x1, y1, z1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid && s_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= s_tdata[31:0];
      y1 <= s_tdata[63:32];
      z1 <= s_tdata[95:64];
    end
  end

  // stage 2: squares, taper product, region and cap depth
  logic               v2;
  logic [63:0]        xx2, yy2;
  logic signed [63:0] p2;
  logic [1:0]         region2;
  logic [34:0]        hhat2;
  logic [31:0]        xm, ym;
  logic signed [31:0] taper_d;
  logic signed [31:0] hbs, hhs;
  logic [34:0]        zx;

  assign xm      = x1[31] ? (~x1 + 32'd1) : x1;
  assign ym      = y1[31] ? (~y1 + 32'd1) : y1;
  assign taper_d = $signed({1'b0, rb}) - $signed({1'b0, rt});
  assign hbs     = $signed({1'b0, hb});
  assign hhs     = $signed({1'b0, hh});
  assign zx      = {{3{z1[31]}}, z1};

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx2 <= 64'(xm) * 64'(xm);
      yy2 <= 64'(ym) * 64'(ym);
      p2  <= z1 * taper_d;
      if (z1 > hbs && z1 < hhs) begin
        region2 <= REGION_BODY;
        hhat2   <= {4'd0, ht} + {4'd0, hh} - zx;
      end else if (z1 <= hbs) begin
        region2 <= REGION_BOTTOM;
        hhat2   <= {4'd0, hb} - zx;
      end else begin
        region2 <= REGION_ABOVE;
        hhat2   <= {4'd0, ht} + {4'd0, hh} - zx;
      end
    end
  end

  // stage 3: radius sum, taper magnitude, cap partial products
  logic        v3;
  logic [63:0] s3, hsq3, pll3;
  logic [62:0] pmag3, phl3;
  logic [33:0] plh3;
  logic        psign3, hneg3, ahbh3;
  logic [1:0]  region3;
  logic [33:0] hmag;
  logic [62:0] a_sel;
  logic [63:0] p2u;

  assign hmag  = hhat2[33:0];
  assign a_sel = (region2 == REGION_BOTTOM) ? a_bot : a_top;
  assign p2u   = p2[63] ? (~p2 + 64'd1) : p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3      <= xx2 + yy2;
      pmag3   <= p2u[62:0];
      psign3  <= p2[63];
      hneg3   <= hhat2[34];
      region3 <= region2;
      hsq3    <= (hmag[33:32] != 2'd0) ? SAT64 : 64'(hmag[31:0]) * 64'(hmag[31:0]);
      pll3    <= 64'(a_sel[31:0]) * 64'(hmag[31:0]);
      phl3    <= 63'(a_sel[62:32]) * 63'(hmag[31:0]);
      plh3    <= 34'(a_sel[31:0]) * 34'(hmag[33:32]);
      ahbh3   <= (a_sel[62:32] != 31'd0) && (hmag[33:32] != 2'd0);
    end
  end

  // stage 4: saturating sides of the cap test
  logic        v4;
  logic [63:0] s4, lhs4, rhs4;
  logic [62:0] pmag4;
  logic        psign4, hneg4;
  logic [1:0]  region4;
  logic [64:0] lsum;
  logic [96:0] rsum;

  assign lsum = {1'b0, s3} + {1'b0, hsq3};
  assign rsum = 97'(pll3) + (97'(phl3) << 32) + (97'(plh3) << 32);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4      <= s3;
      pmag4   <= pmag3;
      psign4  <= psign3;
      hneg4   <= hneg3;
      region4 <= region3;
      lhs4    <= lsum[64] ? SAT64 : lsum[63:0];
      rhs4    <= (ahbh3 || rsum[96:64] != 33'd0) ? SAT64 : rsum[63:0];
    end
  end

  // stage 5 and the divider: one quotient bit of |z*(rB-rT)| / H per stage
  logic        dv   [0:DIV_STEPS];
  logic [30:0] drem [0:DIV_STEPS];
  logic [62:0] dqd  [0:DIV_STEPS];
  ctx_t        dctx [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drem[0] <= '0;
      dqd[0]  <= pmag4;
      dctx[0] <= '{s: s4, region: region4, cap_in: (lhs4 <= rhs4),
                   hneg: hneg4, psign: psign4};
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [31:0] t;
    logic        ge;

    assign t  = {drem[k], dqd[k][62]};
    assign ge = t >= {1'b0, hh};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (en) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        drem[k+1] <= ge ? 31'(t - {1'b0, hh}) : t[30:0];
        dqd[k+1]  <= {dqd[k][61:0], ge};
        dctx[k+1] <= dctx[k];
      end
    end
  end

  // e1: local radius rZ (65-bit signed)
  logic        ve1;
  logic [64:0] rz1;
  ctx_t        ctx1;
  logic [64:0] qs;

  assign qs = dctx[DIV_STEPS].psign ? (~{2'b0, dqd[DIV_STEPS]} + 65'd1)
                                    : {2'b0, dqd[DIV_STEPS]};

  always_ff @(posedge clk) begin
    if (rst) begin
      ve1 <= 1'b0;
    end else if (en) begin
      ve1 <= dv[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // zero height leaves the taper term out
      rz1  <= (hh == 31'd0) ? {34'd0, rb} : ({34'd0, rb} - qs);
      ctx1 <= dctx[DIV_STEPS];
    end
  end

  // e2: magnitude of rZ
  logic        ve2;
  logic        mbig2;
  logic [31:0] mlo2;
  ctx_t        ctx2;
  logic [64:0] rzm;

  assign rzm = rz1[64] ? (~rz1 + 65'd1) : rz1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve2 <= 1'b0;
    end else if (en) begin
      ve2 <= ve1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mbig2 <= rzm[64:32] != 33'd0;
      mlo2  <= rzm[31:0];
      ctx2  <= ctx1;
    end
  end

  // e3: rZ squared, saturating
  logic        ve3;
  logic [63:0] rz2_3;
  ctx_t        ctx3;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve3 <= 1'b0;
    end else if (en) begin
      ve3 <= ve2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rz2_3 <= mbig2 ? SAT64 : 64'(mlo2) * 64'(mlo2);
      ctx3  <= ctx2;
    end
  end

  // e4: decision into the output register
  logic       inside_next;
  logic       in_circle;
  logic       bot_curved, top_curved;
  logic       out_inside;
  logic [1:0] out_region;

  assign in_circle  = ctx3.s <= rz2_3;
  assign bot_curved = hb > {15'd0, eps};
  assign top_curved = ht > {15'd0, eps};

  always_comb begin
    unique case (ctx3.region)
      REGION_BODY:   inside_next = in_circle;
      REGION_BOTTOM: inside_next = in_circle && !(bot_curved && ctx3.cap_in);
      REGION_ABOVE:  inside_next = top_curved && !ctx3.hneg && ctx3.cap_in;
      default:       inside_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= ve3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_inside <= inside_next;
      out_region <= ctx3.region;
    end
  end

  assign m_tdata = {5'd0, out_region, out_inside};

endmodule

`default_nettype wire
